[design/aarm_pkg.sv]
`default_nettype none

package aarm_pkg;

  localparam int FRAC_BITS = 14;

  localparam int ANG_W = 16;
  localparam int AX_W  = 16;
  localparam int OUT_W = 16;
  localparam int N_ENTRY = 9;

  // angle in degrees with 6 fractional bits
  localparam int RED_W = ANG_W + 2;
  localparam logic signed [RED_W-1:0] DEG_FULL    = RED_W'(23040);
  localparam logic signed [RED_W-1:0] DEG_HALF    = RED_W'(11520);
  localparam logic signed [RED_W-1:0] DEG_QUARTER = RED_W'(5760);
  localparam logic signed [RED_W-1:0] DEG_THREEQ  = RED_W'(17280);

  // cordic datapath
  localparam int CORDIC_STEPS = 16;
  localparam int XW = 34;
  localparam int ZW = 26;
  localparam int ATAN_W = 23;
  localparam logic signed [XW-1:0] CORDIC_X0 = XW'(652032874);

  // arctangent of 2^-i in degrees, 16 fractional bits
  localparam logic [ATAN_W-1:0] ATAN_DEG16 [CORDIC_STEPS] = '{
    ATAN_W'(2949120), ATAN_W'(1740967), ATAN_W'(919879), ATAN_W'(466945),
    ATAN_W'(234379),  ATAN_W'(117304),  ATAN_W'(58666),  ATAN_W'(29335),
    ATAN_W'(14668),   ATAN_W'(7334),    ATAN_W'(3667),   ATAN_W'(1833),
    ATAN_W'(917),     ATAN_W'(458),     ATAN_W'(229),    ATAN_W'(115)
  };

  localparam int SUM_W = 64;
  localparam int ONE_Q30_SHIFT = 30;

  typedef struct packed {
    logic signed [AX_W-1:0] z;
    logic signed [AX_W-1:0] y;
    logic signed [AX_W-1:0] x;
  } axis_t;

endpackage

`default_nettype wire

[design/aarm_reduce.sv]
`default_nettype none

module aarm_reduce (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output      logic                              in_ready_o,
  input  wire logic signed [aarm_pkg::ANG_W-1:0] angle_i,
  input  wire aarm_pkg::axis_t                   axis_i,
  output      logic                              out_valid_o,
  input  wire logic                              out_ready_i,
  output      logic signed [aarm_pkg::ZW-1:0]    z_o,
  output      logic                              neg_o,
  output      aarm_pkg::axis_t                   axis_o
);

  logic                                 valid_q;
  logic                                 en;
  logic signed [aarm_pkg::RED_W-1:0]    a_ext, r_mod, r_fold;
  logic                                 neg_d;
  logic signed [aarm_pkg::ZW-1:0]       z_d;
  logic signed [aarm_pkg::ZW-1:0]       z_q;
  logic                                 neg_q;
  aarm_pkg::axis_t                      axis_q;

  assign en         = !valid_q || out_ready_i;
  assign in_ready_o = en;

  // reduce into one turn, then fold into [-90,90] degrees
  always_comb begin
    a_ext = aarm_pkg::RED_W'(angle_i);
    if (a_ext < 0) begin
      r_mod = a_ext + aarm_pkg::DEG_FULL;
      if (r_mod < 0) begin
        r_mod = r_mod + aarm_pkg::DEG_FULL;
      end
    end else if (a_ext >= aarm_pkg::DEG_FULL) begin
      r_mod = a_ext - aarm_pkg::DEG_FULL;
    end else begin
      r_mod = a_ext;
    end
    neg_d = 1'b0;
    if (r_mod >= aarm_pkg::DEG_THREEQ) begin
      r_fold = r_mod - aarm_pkg::DEG_FULL;
    end else if (r_mod > aarm_pkg::DEG_QUARTER) begin
      r_fold = aarm_pkg::DEG_HALF - r_mod;
      neg_d  = 1'b1;
    end else begin
      r_fold = r_mod;
    end
    z_d = aarm_pkg::ZW'(r_fold) <<< 10;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      z_q    <= z_d;
      neg_q  <= neg_d;
      axis_q <= axis_i;
    end
  end

  assign out_valid_o = valid_q;
  assign z_o         = z_q;
  assign neg_o       = neg_q;
  assign axis_o      = axis_q;

endmodule

`default_nettype wire

[design/aarm_cordic.sv]
`default_nettype none

module aarm_cordic (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output      logic                            in_ready_o,
  input  wire logic signed [aarm_pkg::ZW-1:0]  z_i,
  input  wire logic                            neg_i,
  input  wire aarm_pkg::axis_t                 axis_i,
  output      logic                            out_valid_o,
  input  wire logic                            out_ready_i,
  output      logic signed [aarm_pkg::XW-1:0]  x_o,
  output      logic signed [aarm_pkg::XW-1:0]  y_o,
  output      logic                            neg_o,
  output      aarm_pkg::axis_t                 axis_o
);

  localparam int NS = aarm_pkg::CORDIC_STEPS;

  logic [NS-1:0]                     valid_q;
  logic [NS-1:0]                     en;
  logic signed [aarm_pkg::XW-1:0]    x_q [NS];
  logic signed [aarm_pkg::XW-1:0]    y_q [NS];
  logic signed [aarm_pkg::ZW-1:0]    z_q [NS];
  logic                              neg_q [NS];
  aarm_pkg::axis_t                   axis_q [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic signed [aarm_pkg::XW-1:0] xp, yp, x_d, y_d;
    logic signed [aarm_pkg::ZW-1:0] zp, z_d, at;
    logic                           np, vp;
    aarm_pkg::axis_t                ap;

    if (k == 0) begin : g_first
      assign xp = aarm_pkg::CORDIC_X0;
      assign yp = '0;
      assign zp = z_i;
      assign np = neg_i;
      assign ap = axis_i;
      assign vp = in_valid_i;
    end else begin : g_next
      assign xp = x_q[k-1];
      assign yp = y_q[k-1];
      assign zp = z_q[k-1];
      assign np = neg_q[k-1];
      assign ap = axis_q[k-1];
      assign vp = valid_q[k-1];
    end

    if (k == NS - 1) begin : g_last
      assign en[k] = !valid_q[k] || out_ready_i;
    end else begin : g_mid
      assign en[k] = !valid_q[k] || en[k+1];
    end

    assign at = $signed({{(aarm_pkg::ZW - aarm_pkg::ATAN_W){1'b0}}, aarm_pkg::ATAN_DEG16[k]});

    // one micro-rotation, direction from the residual angle
    always_comb begin
      if (zp >= 0) begin
        x_d = xp - (yp >>> k);
        y_d = yp + (xp >>> k);
        z_d = zp - at;
      end else begin
        x_d = xp + (yp >>> k);
        y_d = yp - (xp >>> k);
        z_d = zp + at;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en[k]) begin
        valid_q[k] <= vp;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        x_q[k]    <= x_d;
        y_q[k]    <= y_d;
        z_q[k]    <= z_d;
        neg_q[k]  <= np;
        axis_q[k] <= ap;
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = valid_q[NS-1];
  assign x_o         = x_q[NS-1];
  assign y_o         = y_q[NS-1];
  assign neg_o       = neg_q[NS-1];
  assign axis_o      = axis_q[NS-1];

endmodule

`default_nettype wire

[design/aarm_matrix.sv]
`default_nettype none

module aarm_matrix (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output      logic                            in_ready_o,
  input  wire logic signed [aarm_pkg::XW-1:0]  x_i,
  input  wire logic signed [aarm_pkg::XW-1:0]  y_i,
  input  wire logic                            neg_i,
  input  wire aarm_pkg::axis_t                 axis_i,
  output      logic                            out_valid_o,
  input  wire logic                            out_ready_i,
  output      logic [aarm_pkg::N_ENTRY*aarm_pkg::OUT_W-1:0] m_o
);

  localparam int NST = 4;
  localparam int CW  = aarm_pkg::XW + 1;
  localparam int AAW = 2 * aarm_pkg::AX_W;
  localparam int OHW = CW - 16;
  localparam int PLW = 17 + AAW;
  localparam int PHW = OHW + AAW;
  localparam int SAW = aarm_pkg::XW + aarm_pkg::AX_W;
  localparam int SW  = aarm_pkg::SUM_W;
  localparam int OW  = aarm_pkg::OUT_W;

  // index of a_r*a_k for each entry: xx yy zz xy xz yz
  localparam int AA_IDX [aarm_pkg::N_ENTRY] = '{0, 3, 4, 3, 1, 5, 4, 5, 2};

  logic [NST-1:0] valid_q;
  logic [NST-1:0] en;

  // stage 1: cosine, one minus cosine, sine, axis products
  logic signed [CW-1:0]          c1_d, omc1_d;
  logic signed [CW-1:0]          c1_q, omc1_q;
  logic signed [aarm_pkg::XW-1:0] s1_q;
  logic signed [AAW-1:0]         aa1_q [6];
  aarm_pkg::axis_t               ax1_q;

  // stage 2: partial products
  logic signed [PLW-1:0]         pl2_q [6];
  logic signed [PHW-1:0]         ph2_q [6];
  logic signed [SAW-1:0]         sa2_q [3];
  logic signed [CW-1:0]          c2_q;

  // stage 3: entry sums
  logic signed [SW-1:0]          t3 [6];
  logic signed [SW-1:0]          sk3 [aarm_pkg::N_ENTRY];
  logic signed [SW-1:0]          sx3, sy3, sz3, diag3;
  logic signed [SW-1:0]          sum3_d [aarm_pkg::N_ENTRY];
  logic signed [SW-1:0]          sum3_q [aarm_pkg::N_ENTRY];

  // stage 4: round and saturate
  logic signed [SW-1:0]          rnd4 [aarm_pkg::N_ENTRY];
  logic        [OW-1:0]          m4_d [aarm_pkg::N_ENTRY];
  logic        [OW-1:0]          m4_q [aarm_pkg::N_ENTRY];

  for (genvar k = 0; k < NST; k++) begin : g_ctl
    logic vp;
    if (k == 0) begin : g_first
      assign vp = in_valid_i;
    end else begin : g_next
      assign vp = valid_q[k-1];
    end
    if (k == NST - 1) begin : g_last
      assign en[k] = !valid_q[k] || out_ready_i;
    end else begin : g_mid
      assign en[k] = !valid_q[k] || en[k+1];
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en[k]) begin
        valid_q[k] <= vp;
      end
    end
  end

  assign c1_d   = neg_i ? -CW'(x_i) : CW'(x_i);
  assign omc1_d = (CW'(1) <<< aarm_pkg::ONE_Q30_SHIFT) - c1_d;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      c1_q     <= c1_d;
      omc1_q   <= omc1_d;
      s1_q     <= y_i;
      ax1_q    <= axis_i;
      aa1_q[0] <= axis_i.x * axis_i.x;
      aa1_q[1] <= axis_i.y * axis_i.y;
      aa1_q[2] <= axis_i.z * axis_i.z;
      aa1_q[3] <= axis_i.x * axis_i.y;
      aa1_q[4] <= axis_i.x * axis_i.z;
      aa1_q[5] <= axis_i.y * axis_i.z;
    end
  end

  // omc split into a signed high part and an unsigned low 16 bits
  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      for (int j = 0; j < 6; j++) begin
        pl2_q[j] <= $signed({1'b0, omc1_q[15:0]}) * aa1_q[j];
        ph2_q[j] <= $signed(omc1_q[CW-1:16]) * aa1_q[j];
      end
      sa2_q[0] <= s1_q * ax1_q.x;
      sa2_q[1] <= s1_q * ax1_q.y;
      sa2_q[2] <= s1_q * ax1_q.z;
      c2_q     <= c1_q;
    end
  end

  always_comb begin
    for (int j = 0; j < 6; j++) begin
      t3[j] = ((SW'(ph2_q[j]) <<< 16) + SW'(pl2_q[j])) >>> aarm_pkg::FRAC_BITS;
    end
    sx3   = SW'(sa2_q[0]);
    sy3   = SW'(sa2_q[1]);
    sz3   = SW'(sa2_q[2]);
    diag3 = SW'(c2_q) <<< aarm_pkg::FRAC_BITS;
    sk3[0] = '0;
    sk3[1] = sz3;
    sk3[2] = -sy3;
    sk3[3] = -sz3;
    sk3[4] = '0;
    sk3[5] = sx3;
    sk3[6] = sy3;
    sk3[7] = -sx3;
    sk3[8] = '0;
    for (int e = 0; e < aarm_pkg::N_ENTRY; e++) begin
      sum3_d[e] = t3[AA_IDX[e]] + sk3[e];
      if (e == 0 || e == 4 || e == 8) begin
        sum3_d[e] = sum3_d[e] + diag3;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      sum3_q <= sum3_d;
    end
  end

  // round half up at bit 30, then clamp to 16 bits
  always_comb begin
    for (int e = 0; e < aarm_pkg::N_ENTRY; e++) begin
      rnd4[e] = (sum3_q[e] + (SW'(1) <<< (aarm_pkg::ONE_Q30_SHIFT - 1)))
                >>> aarm_pkg::ONE_Q30_SHIFT;
      if (rnd4[e] > SW'(32767)) begin
        m4_d[e] = OW'(32767);
      end else if (rnd4[e] < -SW'(32768)) begin
        m4_d[e] = OW'(32768);
      end else begin
        m4_d[e] = rnd4[e][OW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      m4_q <= m4_d;
    end
  end

  for (genvar e = 0; e < aarm_pkg::N_ENTRY; e++) begin : g_out
    assign m_o[e*OW +: OW] = m4_q[e];
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = valid_q[NST-1];

endmodule

`default_nettype wire

[design/axis_angle_rotation_matrix.sv]
`default_nettype none

// channel   direction  tdata fields (lsb first)                       tuser/tlast
// s_axis    in         angle_deg, axis_x, axis_y, axis_z (16b each)     none
// m_axis    out        m00 m01 m02 m10 m11 m12 m20 m21 m22 (16b each)   none
//
// the pipeline has 1 angle reduction stage, 16 cordic stages (one
// micro-rotation each) and 4 matrix stages (products, partial products,
// sums, round/saturate); a new transaction can enter every cycle unless m_axis stalls.
// each stage has its own valid bit and takes new data when it is empty or
// its successor moves, so bubbles close up and a stall on m_axis fills the
// pipe before s_axis_tready drops. reset clears only the valid bits.

module axis_angle_rotation_matrix (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_axis_tvalid,
  output      logic          s_axis_tready,
  input  wire logic [63:0]   s_axis_tdata,   // angle_deg, axis_x, axis_y, axis_z
  output      logic          m_axis_tvalid,
  input  wire logic          m_axis_tready,
  output      logic [143:0]  m_axis_tdata    // m00 m01 m02 m10 m11 m12 m20 m21 m22
);

  aarm_pkg::axis_t                    axis_in;
  aarm_pkg::axis_t                    axis_red, axis_cor;
  logic                               red_valid, red_ready;
  logic                               cor_valid, cor_ready;
  logic signed [aarm_pkg::ZW-1:0]     red_z;
  logic                               red_neg, cor_neg;
  logic signed [aarm_pkg::XW-1:0]     cor_x, cor_y;

  assign axis_in.x = $signed(s_axis_tdata[31:16]);
  assign axis_in.y = $signed(s_axis_tdata[47:32]);
  assign axis_in.z = $signed(s_axis_tdata[63:48]);

  // fold angle into the cordic's convergence range
  aarm_reduce u_reduce (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .angle_i     ($signed(s_axis_tdata[15:0])),
    .axis_i      (axis_in),
    .out_valid_o (red_valid),
    .out_ready_i (red_ready),
    .z_o         (red_z),
    .neg_o       (red_neg),
    .axis_o      (axis_red)
  );

  // cosine and sine in q30
  aarm_cordic u_cordic (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (red_valid),
    .in_ready_o  (red_ready),
    .z_i         (red_z),
    .neg_i       (red_neg),
    .axis_i      (axis_red),
    .out_valid_o (cor_valid),
    .out_ready_i (cor_ready),
    .x_o         (cor_x),
    .y_o         (cor_y),
    .neg_o       (cor_neg),
    .axis_o      (axis_cor)
  );

  // rodrigues entries, last stage is the output register
  aarm_matrix u_matrix (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cor_valid),
    .in_ready_o  (cor_ready),
    .x_i         (cor_x),
    .y_i         (cor_y),
    .neg_i       (cor_neg),
    .axis_i      (axis_cor),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .m_o         (m_axis_tdata)
  );

endmodule

`default_nettype wire
